// File: sv/four_pole_ladder_lowpass_top_defines.svh
// Assertion macros for the ladder filter. Both expect clk and rst_n in scope.
`ifndef FOUR_POLE_LADDER_LOWPASS_TOP_DEFINES_SVH
`define FOUR_POLE_LADDER_LOWPASS_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset only
`define FPLL_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset only
`define FPLL_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/fpll_pkg.sv
package fpll_pkg;

  // Default parameter values for the top level
  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int STATE_WIDTH_DEF  = 32;
  localparam int CUTOFF_MAX_DEF   = 8140;

  // Fixed field widths
  localparam int CUT_W = 13;
  localparam int RES_W = 18;

  // Coefficient width: Q1.15 plus headroom for the pole and resonance ranges
  localparam int CW = 17;
  localparam int UW = 16;

  // Serial divider and multiplier sizes
  localparam int NUMW      = 28;
  localparam int DENW      = 14;
  localparam int DIV_CNT_W = $clog2(NUMW);
  localparam int MUL_CNT_W = $clog2(CW);

  // Ladder depth
  localparam int NSTAGE = 4;
  localparam int STG_W  = $clog2(NSTAGE);

  // Resonance limit (4.0 in Q4.13) and the high-cutoff knee
  localparam logic [RES_W-1:0] RES_MAX    = RES_W'(32768);
  localparam logic [CUT_W-1:0] KNEE       = CUT_W'(3800);
  localparam int               KNEE_SHIFT = 13;
  localparam logic [NUMW-1:0]  KNEE_RND   = NUMW'(4300);
  localparam logic [DENW-1:0]  KNEE_DIV   = DENW'(8600);

  // Cutoff to pole: u = round(f * 2^15 / 7100)
  localparam int               U_SHIFT = 15;
  localparam logic [NUMW-1:0]  U_RND   = NUMW'(3550);
  localparam logic [DENW-1:0]  U_DIV   = DENW'(7100);

  // Stage gain: pt1 = round(u * 10 / 13)
  localparam logic [NUMW-1:0]  G_RND = NUMW'(6);
  localparam logic [DENW-1:0]  G_DIV = DENW'(13);

  // Pole bias (1.0 in Q1.15) and the 0.3 input tap
  localparam logic [CW-1:0] PT_BIAS = CW'(32768);
  localparam logic [CW-1:0] COEF_03 = CW'(9830);

  // Product scaling
  localparam int FB_SHIFT = 13;
  localparam int ST_SHIFT = 15;

  // Status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_st_t;

endpackage

// File: sv/fpll_sdiv.sv
// Restoring divider, one quotient bit per cycle. The numerator register
// shifts out its top bit and takes the new quotient bit at the bottom.
module fpll_sdiv import fpll_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [NUMW-1:0] num,
  input  logic [DENW-1:0] den,
  output unit_st_t        st,
  output logic [NUMW-1:0] quo
);

  logic [NUMW-1:0]      num_r, num_nxt;
  logic [DENW-1:0]      rem_r, rem_nxt;
  logic [DENW-1:0]      den_r, den_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;

  logic [DENW:0] trial;
  logic [DENW:0] diff;
  logic          ge;

  // Trial subtract of the divisor from the partial remainder
  assign trial = {rem_r, num_r[NUMW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  // Load on start, then one step per cycle
  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = DIV_CNT_W'(NUMW - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[NUMW-2:0], ge};
      rem_nxt = ge ? diff[DENW-1:0] : trial[DENW-1:0];
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign st.busy = busy_r;
  assign st.done = done_r;
  assign quo     = num_r;

endmodule

// File: sv/fpll_smul.sv
// Signed shift-add multiplier, one coefficient bit per cycle, LSB first.
// The low half of the product register starts as the coefficient and
// fills with product bits as the coefficient bits are consumed.
module fpll_smul import fpll_pkg::*; #(
  parameter int MCAND_W = STATE_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [CW-1:0]      coef,
  input  logic signed [MCAND_W-1:0] mcand,
  output unit_st_t                  st,
  output logic signed [MCAND_W+CW:0] prod
);

  logic signed [MCAND_W:0]   hi_r, hi_nxt;
  logic [CW-1:0]             lo_r, lo_nxt;
  logic signed [MCAND_W-1:0] m_r, m_nxt;
  logic [MUL_CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;

  logic signed [MCAND_W+1:0] m_ext;
  logic signed [MCAND_W+1:0] hi_ext;
  logic signed [MCAND_W+1:0] addend;
  logic signed [MCAND_W+1:0] sum;

  // Add or, for the sign bit of the coefficient, subtract the multiplicand
  assign m_ext  = {{2{m_r[MCAND_W-1]}}, m_r};
  assign hi_ext = {hi_r[MCAND_W], hi_r};
  assign addend = !lo_r[0] ? '0 : ((cnt_r == '0) ? -m_ext : m_ext);
  assign sum    = hi_ext + addend;

  // Load on start, then accumulate and shift right once per cycle
  always_comb begin
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    m_nxt    = m_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      hi_nxt   = '0;
      lo_nxt   = coef;
      m_nxt    = mcand;
      cnt_nxt  = MUL_CNT_W'(CW - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      hi_nxt = sum[MCAND_W+1:1];
      lo_nxt = {sum[0], lo_r[CW-1:1]};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
    m_r  <= m_nxt;
  end

  assign st.busy = busy_r;
  assign st.done = done_r;
  assign prod    = {hi_r, lo_r};

endmodule

// File: sv/four_pole_ladder_lowpass_top.sv
// Channel  Direction  Handshake           Word
// in_      input      in_valid/in_stall   in_sample_in, in_cutoff, in_resonance
// out_     output     out_valid/out_stall out_filtered_out
//
// Each word runs three 28-step divisions in the bit-serial divider and
// thirteen 17-step products in the bit-serial multiplier, one after the
// other, plus accept and output.
// rst_n (synchronous) clears the sequencer, the output valid flag and all
// four stages' input and output history.
// A finished word waits in the output register under out_stall; the next input
// word is taken meanwhile and only its final write waits for the register.
`include "four_pole_ladder_lowpass_top_defines.svh"

module four_pole_ladder_lowpass_top import fpll_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int STATE_WIDTH  = STATE_WIDTH_DEF,
  parameter int CUTOFF_MAX   = CUTOFF_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_in,
  input  logic [CUT_W-1:0]               in_cutoff,
  input  logic signed [RES_W-1:0]        in_resonance,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_filtered_out
);

  localparam int SW = STATE_WIDTH;
  localparam int XW = SAMPLE_WIDTH;
  localparam int MW = (SW > XW) ? SW : XW;
  localparam int RW = MW + 6;
  localparam int PW = SW + CW + 1;
  localparam logic [STG_W-1:0] STG_LAST = STG_W'(NSTAGE - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_KDIV,
    S_UDIV,
    S_GDIV,
    S_FB,
    S_M1,
    S_M2,
    S_M3,
    S_OUT
  } state_t;

  // Round to nearest (ties up) and scale a product back to the state format
  function automatic logic signed [RW-1:0] rnd_sh(input logic signed [PW-1:0] p,
                                                   input logic fb);
    logic signed [PW:0] pe;
    logic signed [PW:0] sh;
    pe = {p[PW-1], p};
    if (fb) begin
      sh = (pe + (PW+1)'(1 << (FB_SHIFT - 1))) >>> FB_SHIFT;
    end else begin
      sh = (pe + (PW+1)'(1 << (ST_SHIFT - 1))) >>> ST_SHIFT;
    end
    return sh[RW-1:0];
  endfunction

  // Saturate to the state width
  function automatic logic signed [SW-1:0] sat_st(input logic signed [RW-1:0] v);
    logic [RW-SW:0] top_bits;
    top_bits = v[RW-1:SW-1];
    if ((&top_bits) || !(|top_bits)) begin
      return v[SW-1:0];
    end else if (v[RW-1]) begin
      return {1'b1, {(SW-1){1'b0}}};
    end else begin
      return {1'b0, {(SW-1){1'b1}}};
    end
  endfunction

  // Saturate to the sample width
  function automatic logic signed [XW-1:0] sat_smp(input logic signed [RW-1:0] v);
    logic [RW-XW:0] top_bits;
    top_bits = v[RW-1:XW-1];
    if ((&top_bits) || !(|top_bits)) begin
      return v[XW-1:0];
    end else if (v[RW-1]) begin
      return {1'b1, {(XW-1){1'b0}}};
    end else begin
      return {1'b0, {(XW-1){1'b1}}};
    end
  endfunction

  state_t state_r, state_nxt;
  logic   start_r, start_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic [STG_W-1:0] stg_r, stg_nxt;

  logic signed [XW-1:0] x_r, x_nxt;
  logic [CUT_W-1:0]     f_r, f_nxt;
  logic signed [CW-1:0] k_r, k_nxt;
  logic [UW-1:0]        u_r, u_nxt;
  logic signed [CW-1:0] pt1_r, pt1_nxt;
  logic signed [SW-1:0] drive_r, drive_nxt;
  logic signed [SW-1:0] sum_r, sum_nxt;
  logic signed [RW-1:0] t_r, t_nxt;
  logic signed [XW-1:0] out_data_r, out_data_nxt;

  // Stage history; index 0 is always the stage being worked on
  logic signed [SW-1:0] sd_r [NSTAGE];
  logic signed [SW-1:0] sd_nxt [NSTAGE];
  logic signed [SW-1:0] so_r [NSTAGE];
  logic signed [SW-1:0] so_nxt [NSTAGE];

  unit_st_t             div_st;
  unit_st_t             mul_st;
  logic                 div_start;
  logic                 mul_start;
  logic [NUMW-1:0]      div_num;
  logic [DENW-1:0]      div_den;
  logic [NUMW-1:0]      quo;
  logic signed [CW-1:0] mul_coef;
  logic signed [SW-1:0] mul_mcand;
  logic signed [PW-1:0] prod;

  logic [NUMW-1:0]      knee_num;
  logic [NUMW-1:0]      u_num;
  logic [NUMW-1:0]      g_num;
  logic signed [CW-1:0] pt_w;
  logic signed [RW-1:0] r_fb;
  logic signed [RW-1:0] r_st;
  logic signed [SW-1:0] drive_fb;
  logic signed [SW-1:0] sum_st;
  logic signed [SW-1:0] y_st;
  logic signed [CW-1:0] k_clamp;
  logic [CUT_W-1:0]     f_clamp;

  // Clamp the incoming cutoff and resonance
  assign f_clamp = (in_cutoff > CUT_W'(CUTOFF_MAX)) ? CUT_W'(CUTOFF_MAX) : in_cutoff;
  assign k_clamp = in_resonance[RES_W-1] ? '0 :
                   ((in_resonance > RES_MAX) ? CW'(RES_MAX) : in_resonance[CW-1:0]);

  // Divider numerators: knee correction, pole and gain (10u as 8u + 2u)
  assign knee_num = (f_r > KNEE) ? NUMW'({f_r - KNEE, {KNEE_SHIFT{1'b0}}}) + KNEE_RND
                                 : '0;
  assign u_num    = NUMW'({f_r, {U_SHIFT{1'b0}}}) + U_RND;
  assign g_num    = NUMW'({u_r, 3'b000}) + NUMW'({u_r, 1'b0}) + G_RND;
  assign pt_w     = $signed({1'b0, u_r}) - $signed(PT_BIAS);

  // Scaled products and the saturated results built from them
  assign r_fb     = rnd_sh(prod, 1'b1);
  assign r_st     = rnd_sh(prod, 1'b0);
  assign drive_fb = sat_st({{(RW-XW){x_r[XW-1]}}, x_r} - r_fb);
  assign sum_st   = sat_st({{(RW-SW){drive_r[SW-1]}}, drive_r} + r_st);
  assign y_st     = sat_st(t_r - r_st);

  // Start only the unit that the current step uses
  assign div_start = start_r && (state_r inside {S_KDIV, S_UDIV, S_GDIV});
  assign mul_start = start_r && (state_r inside {S_FB, S_M1, S_M2, S_M3});

  // Route operands to the divider
  always_comb begin
    unique case (state_r)
      S_KDIV: begin
        div_num = knee_num;
        div_den = KNEE_DIV;
      end
      S_UDIV: begin
        div_num = u_num;
        div_den = U_DIV;
      end
      S_GDIV: begin
        div_num = g_num;
        div_den = G_DIV;
      end
      default: begin
        div_num = '0;
        div_den = G_DIV;
      end
    endcase
  end

  // Route operands to the multiplier
  always_comb begin
    unique case (state_r)
      S_FB: begin
        mul_coef  = k_r;
        mul_mcand = so_r[NSTAGE-1];
      end
      S_M1: begin
        mul_coef  = COEF_03;
        mul_mcand = sd_r[0];
      end
      S_M2: begin
        mul_coef  = pt1_r;
        mul_mcand = sum_r;
      end
      S_M3: begin
        mul_coef  = pt_w;
        mul_mcand = so_r[0];
      end
      default: begin
        mul_coef  = '0;
        mul_mcand = '0;
      end
    endcase
  end

  fpll_sdiv u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .st    (div_st),
    .quo   (quo)
  );

  fpll_smul #(
    .MCAND_W (SW)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .coef  (mul_coef),
    .mcand (mul_mcand),
    .st    (mul_st),
    .prod  (prod)
  );

  // Sequencer: coefficients, feedback, then four stages of three products
  always_comb begin
    state_nxt     = state_r;
    start_nxt     = 1'b0;
    out_valid_nxt = out_valid_r;
    stg_nxt       = stg_r;
    x_nxt         = x_r;
    f_nxt         = f_r;
    k_nxt         = k_r;
    u_nxt         = u_r;
    pt1_nxt       = pt1_r;
    drive_nxt     = drive_r;
    sum_nxt       = sum_r;
    t_nxt         = t_r;
    out_data_nxt  = out_data_r;
    sd_nxt        = sd_r;
    so_nxt        = so_r;

    // Drop the output word once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          x_nxt     = in_sample_in;
          f_nxt     = f_clamp;
          k_nxt     = k_clamp;
          state_nxt = S_KDIV;
          start_nxt = 1'b1;
        end
      end
      S_KDIV: begin
        if (div_st.done) begin
          k_nxt     = k_r - quo[CW-1:0];
          state_nxt = S_UDIV;
          start_nxt = 1'b1;
        end
      end
      S_UDIV: begin
        if (div_st.done) begin
          u_nxt     = quo[UW-1:0];
          state_nxt = S_GDIV;
          start_nxt = 1'b1;
        end
      end
      S_GDIV: begin
        if (div_st.done) begin
          pt1_nxt   = quo[CW-1:0];
          state_nxt = S_FB;
          start_nxt = 1'b1;
        end
      end
      S_FB: begin
        if (mul_st.done) begin
          drive_nxt = drive_fb;
          stg_nxt   = '0;
          state_nxt = S_M1;
          start_nxt = 1'b1;
        end
      end
      S_M1: begin
        if (mul_st.done) begin
          sum_nxt   = sum_st;
          state_nxt = S_M2;
          start_nxt = 1'b1;
        end
      end
      S_M2: begin
        if (mul_st.done) begin
          t_nxt     = r_st;
          state_nxt = S_M3;
          start_nxt = 1'b1;
        end
      end
      S_M3: begin
        if (mul_st.done) begin
          // Advance the history ring; the finished stage goes to the back
          for (int j = 0; j < NSTAGE - 1; j++) begin
            sd_nxt[j] = sd_r[j+1];
            so_nxt[j] = so_r[j+1];
          end
          sd_nxt[NSTAGE-1] = drive_r;
          so_nxt[NSTAGE-1] = y_st;
          drive_nxt        = y_st;
          if (stg_r == STG_LAST) begin
            state_nxt = S_OUT;
          end else begin
            stg_nxt   = stg_r + 1'b1;
            state_nxt = S_M1;
            start_nxt = 1'b1;
          end
        end
      end
      S_OUT: begin
        // Hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = sat_smp({{(RW-SW){so_r[NSTAGE-1][SW-1]}}, so_r[NSTAGE-1]});
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
      stg_r       <= '0;
      for (int j = 0; j < NSTAGE; j++) begin
        sd_r[j] <= '0;
        so_r[j] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
      stg_r       <= stg_nxt;
      sd_r        <= sd_nxt;
      so_r        <= so_nxt;
    end
    x_r        <= x_nxt;
    f_r        <= f_nxt;
    k_r        <= k_nxt;
    u_r        <= u_nxt;
    pt1_r      <= pt1_nxt;
    drive_r    <= drive_nxt;
    sum_r      <= sum_nxt;
    t_r        <= t_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_filtered_out = out_data_r;

  `FPLL_ASSERT_IMP(a_units_exclusive, div_st.busy, !mul_st.busy, "divider and multiplier both busy")
  `FPLL_ASSERT_IMP(a_start_idle, start_r, !div_st.busy && !mul_st.busy, "unit started while busy")
  `FPLL_ASSERT_IMP(a_out_after_last, state_r == S_OUT, stg_r == STG_LAST, "output before last stage")
  `FPLL_ASSERT_NXT(a_out_write_src, (state_r != S_OUT) && !out_valid_r, !out_valid_r, "output set outside final step")
  `FPLL_ASSERT_NXT(a_accept_starts, in_valid && !in_stall, start_r && (state_r == S_KDIV), "accepted word did not start")

endmodule
